/* hw/rtl/read_quality_window_trim_filter_macros.svh */
// Assertion macros for the read quality window trim filter.
`ifndef READ_QUALITY_WINDOW_TRIM_FILTER_MACROS_SVH
`define READ_QUALITY_WINDOW_TRIM_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
// The antecedent implies the consequent in the same cycle.
`define RQWTF_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);
// The antecedent implies the consequent in the next cycle.
`define RQWTF_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RQWTF_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define RQWTF_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif

`endif

/* hw/rtl/rqwtf_pkg.sv */
// Shared types, constants and helper functions of the read quality window trim filter.
package rqwtf_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int WIN_AW     = $clog2(MAX_WINDOW);
  localparam int POS_W      = 16;
  localparam int K_W        = 7;
  localparam int Q_W        = 7;
  localparam int QSUM_W     = 23;
  localparam int NCNT_W     = 16;
  localparam int WSUM_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int VERDICT_W  = 3;

  localparam logic [POS_W-1:0] MAX_READ_LENGTH = 16'hFFFF;
  localparam logic [7:0]       QUAL_OFFSET     = 8'd33;
  localparam logic [Q_W-1:0]   QUAL_MAX        = 7'd93;
  localparam logic [7:0]       BASE_N          = 8'h4E;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_N_COUNT         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW_QUALITY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_AVERAGE_QUALITY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_READ_LENGTH     = 3'd4;

  // Verdict codes.
  localparam logic [VERDICT_W-1:0] VERDICT_KEEP    = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_MANY_N  = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_LOW_AVG = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_SHORT   = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_EMPTY   = 3'd4;

  typedef struct packed {
    logic [15:0]    max_n_count;
    logic [K_W-1:0] window_size;
    logic [Q_W-1:0] min_window_quality;
    logic [Q_W-1:0] min_average_quality;
    logic [15:0]    min_read_length;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    max_n_count:         16'd0,
    window_size:         7'd5,
    min_window_quality:  7'd25,
    min_average_quality: 7'd25,
    min_read_length:     16'd35
  };

  // One base on its way from the issue stage to the update stage.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [K_W-1:0]   k;
    logic [Q_W-1:0]   qual;
    logic             is_n;
    logic             last;
    logic             active;
  } issue_t;

  // Running totals up to and including one position.
  typedef struct packed {
    logic [QSUM_W-1:0] qsum;
    logic [NCNT_W-1:0] ncnt;
  } prefix_t;

  typedef struct packed {
    logic [POS_W-1:0]  read_length;
    logic [POS_W-1:0]  trimmed_length;
    logic [NCNT_W-1:0] ncnt;
    logic [QSUM_W-1:0] qsum;
  } record_t;

  function automatic logic [K_W-1:0] effective_window(logic [K_W-1:0] ws);
    logic [K_W-1:0] k;
    k = ws;
    if (ws == '0) begin
      k = K_W'(1);
    end else if (int'(ws) > MAX_WINDOW) begin
      k = K_W'(MAX_WINDOW);
    end
    return k;
  endfunction

  function automatic logic [Q_W-1:0] phred_quality(logic [7:0] qc);
    logic [7:0]     d;
    logic [Q_W-1:0] q;
    d = qc - QUAL_OFFSET;
    if (qc < QUAL_OFFSET) begin
      q = '0;
    end else if (d > 8'(QUAL_MAX)) begin
      q = QUAL_MAX;
    end else begin
      q = d[Q_W-1:0];
    end
    return q;
  endfunction

endpackage

/* hw/rtl/rqwtf_if.sv */
// Handshake channel interfaces of the read quality window trim filter.
interface rqwtf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_char;
  logic [7:0] quality_char;
  logic       last;

  modport source (output valid, base_char, quality_char, last, input ready);
  modport sink (input valid, base_char, quality_char, last, output ready);
endinterface

interface rqwtf_out_if;
  logic                             valid;
  logic                             ready;
  logic                             keep;
  logic [rqwtf_pkg::VERDICT_W-1:0]  verdict;
  logic [rqwtf_pkg::POS_W-1:0]      trimmed_length;
  logic [rqwtf_pkg::POS_W-1:0]      read_length;
  logic [rqwtf_pkg::NCNT_W-1:0]     n_count;
  logic [rqwtf_pkg::QSUM_W-1:0]     quality_sum;

  modport source (output valid, keep, verdict, trimmed_length, read_length, n_count,
                  quality_sum, input ready);
  modport sink (input valid, keep, verdict, trimmed_length, read_length, n_count,
                quality_sum, output ready);
endinterface

interface rqwtf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rqwtf_pkg::CFG_IDX_W-1:0]   index;
  logic [rqwtf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/read_quality_window_trim_filter.sv */
// Path: the last item of a read is held in the stage register s1, and its totals then go to
// the result register, where results.valid rises; s1 holds it while the result slot is full.
// Throughput: one item per cycle, sustained, set by the single read port of the prefix memory.
// Only a last item may wait, and only while the previous result has not been taken.
// Reset (rst, synchronous, active high) clears all counters, flags and handshake state and
// restores the register defaults; the prefix memory is not cleared, as only those of its
// totals that were written earlier in the same read are ever used.
module read_quality_window_trim_filter (
  input  logic         clk,
  input  logic         rst,
  rqwtf_in_if.sink     bases,
  rqwtf_out_if.source  results,
  rqwtf_cfg_if.sink    cfg
);

`include "read_quality_window_trim_filter_macros.svh"

  // The design keeps, for every position of the current read, the running quality sum and
  // N count up to and including that position, in a ring memory as deep as the largest window.
  // The sum of a window is then the running sum less the stored total of the position just
  // before the window, and trimming at a window start restores the totals stored there.
  // Each item reads one entry, the one of its window start; the same data, carried one item
  // further, is the entry just before the next item's window, so one read port serves both.

  rqwtf_pkg::cfg_t                  regs;
  rqwtf_pkg::issue_t                s1;
  logic                             s1_fire;
  logic                             out_free;
  logic                             rd_en;
  logic [rqwtf_pkg::WIN_AW-1:0]     rd_addr;
  rqwtf_pkg::prefix_t               rd_data;
  logic                             wr_en;
  logic [rqwtf_pkg::WIN_AW-1:0]     wr_addr;
  rqwtf_pkg::prefix_t               wr_data;
  rqwtf_pkg::record_t               rec;
  logic                             rec_valid;
  logic                             result_held;
  logic                             trim_ok;
  logic                             totals_ok;

  rqwtf_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Stage one: take the item, count its position and issue the memory read.
  rqwtf_issue u_issue (
    .clk         (clk),
    .rst         (rst),
    .bases       (bases),
    .window_size (regs.window_size),
    .out_free    (out_free),
    .s1          (s1),
    .s1_fire     (s1_fire),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr)
  );

  // The memory forwards a write to a read of the same slot in the same cycle, which covers
  // a window of two, where an item reads the entry that the item before it is writing.
  rqwtf_prefix_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Stage two: update the totals, check the window, trim and write the totals back.
  rqwtf_update u_update (
    .clk                (clk),
    .rst                (rst),
    .s1                 (s1),
    .s1_fire            (s1_fire),
    .min_window_quality (regs.min_window_quality),
    .rd_data            (rd_data),
    .wr_en              (wr_en),
    .wr_addr            (wr_addr),
    .wr_data            (wr_data),
    .rec                (rec),
    .rec_valid          (rec_valid)
  );

  // Result register; the verdict is formed from the held totals and the registers.
  rqwtf_verdict u_verdict (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .rec       (rec),
    .rec_valid (rec_valid),
    .out_free  (out_free),
    .results   (results)
  );

  // Conditions checked below, kept short so that each check fits on one line.
  assign result_held = results.valid && !results.ready;
  assign trim_ok     = results.trimmed_length <= results.read_length;
  assign totals_ok   = (results.n_count <= results.read_length)
                       && (results.quality_sum <= rqwtf_pkg::QSUM_W'(rqwtf_pkg::QUAL_MAX)
                           * rqwtf_pkg::QSUM_W'(results.read_length));

  // Input back-pressure only ever comes from a result that has not yet been taken.
  `RQWTF_ASSERT_IMP(a_stall_only_on_result, clk, rst, !bases.ready, result_held, "input stalled")

  // The trim point never lies beyond the end of the read.
  `RQWTF_ASSERT_IMP(a_trim_within_read, clk, rst, results.valid, trim_ok, "trim past end")

  // The counted totals fit the number of bases in the read.
  `RQWTF_ASSERT_IMP(a_totals_bounded, clk, rst, results.valid, totals_ok, "totals too large")

endmodule

/* hw/rtl/rqwtf_prefix_ram.sv */
// Ring memory of running quality and N totals, one entry per window slot, with write bypass.
module rqwtf_prefix_ram (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [rqwtf_pkg::WIN_AW-1:0]     wr_addr,
  input  rqwtf_pkg::prefix_t               wr_data,
  input  logic                             rd_en,
  input  logic [rqwtf_pkg::WIN_AW-1:0]     rd_addr,
  output rqwtf_pkg::prefix_t               rd_data
);

  rqwtf_pkg::prefix_t mem [rqwtf_pkg::MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read that meets a write to the same slot returns the new data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

/* hw/rtl/rqwtf_cfg.sv */
// Configuration register bank of the read quality window trim filter.
module rqwtf_cfg (
  input  logic               clk,
  input  logic               rst,
  rqwtf_cfg_if.sink          cfg,
  output rqwtf_pkg::cfg_t    regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= rqwtf_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rqwtf_pkg::REG_MAX_N_COUNT: begin
          regs.max_n_count <= cfg.data;
        end
        rqwtf_pkg::REG_WINDOW_SIZE: begin
          regs.window_size <= cfg.data[rqwtf_pkg::K_W-1:0];
        end
        rqwtf_pkg::REG_MIN_WINDOW_QUALITY: begin
          regs.min_window_quality <= cfg.data[rqwtf_pkg::Q_W-1:0];
        end
        rqwtf_pkg::REG_MIN_AVERAGE_QUALITY: begin
          regs.min_average_quality <= cfg.data[rqwtf_pkg::Q_W-1:0];
        end
        rqwtf_pkg::REG_MIN_READ_LENGTH: begin
          regs.min_read_length <= cfg.data;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* hw/rtl/rqwtf_issue.sv */
// Issue stage: position counter, window latch, memory read issue and the stage register.
module rqwtf_issue (
  input  logic                             clk,
  input  logic                             rst,
  rqwtf_in_if.sink                         bases,
  input  logic [rqwtf_pkg::K_W-1:0]        window_size,
  input  logic                             out_free,
  output rqwtf_pkg::issue_t                s1,
  output logic                             s1_fire,
  output logic                             rd_en,
  output logic [rqwtf_pkg::WIN_AW-1:0]     rd_addr
);

  logic                           s1_valid;
  logic [rqwtf_pkg::POS_W-1:0]    pos;
  logic [rqwtf_pkg::K_W-1:0]      k_reg;
  logic [rqwtf_pkg::K_W-1:0]      k_cur;
  logic                           accept;

  // A base leaves the stage unless it ends a read and the result slot is full.
  assign s1_fire     = s1_valid && (!s1.last || out_free);
  assign bases.ready = !s1_valid || s1_fire;
  assign accept      = bases.valid && bases.ready;

  // The window length is taken from the register at the first base of each read.
  assign k_cur = (pos == '0) ? rqwtf_pkg::effective_window(window_size) : k_reg;

  // Fetch the totals of the position at which this base's window starts.
  assign rd_en   = accept;
  assign rd_addr = pos[rqwtf_pkg::WIN_AW-1:0] + rqwtf_pkg::WIN_AW'(1)
                   - k_cur[rqwtf_pkg::WIN_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      pos      <= '0;
      k_reg    <= rqwtf_pkg::K_W'(1);
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        k_reg    <= k_cur;
        if (bases.last) begin
          pos <= '0;
        end else if (pos != rqwtf_pkg::MAX_READ_LENGTH) begin
          pos <= pos + rqwtf_pkg::POS_W'(1);
        end
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.pos    <= pos;
      s1.k      <= k_cur;
      s1.qual   <= rqwtf_pkg::phred_quality(bases.quality_char);
      s1.is_n   <= (bases.base_char == rqwtf_pkg::BASE_N);
      s1.last   <= bases.last;
      s1.active <= (pos != rqwtf_pkg::MAX_READ_LENGTH);
    end
  end

endmodule

/* hw/rtl/rqwtf_update.sv */
// Update stage: running totals, window check, trim decision and memory write-back.
module rqwtf_update (
  input  logic                             clk,
  input  logic                             rst,
  input  rqwtf_pkg::issue_t                s1,
  input  logic                             s1_fire,
  input  logic [rqwtf_pkg::Q_W-1:0]        min_window_quality,
  input  rqwtf_pkg::prefix_t               rd_data,
  output logic                             wr_en,
  output logic [rqwtf_pkg::WIN_AW-1:0]     wr_addr,
  output rqwtf_pkg::prefix_t               wr_data,
  output rqwtf_pkg::record_t               rec,
  output logic                             rec_valid
);

  logic                              trimmed;
  logic [rqwtf_pkg::POS_W-1:0]       trim_point;
  rqwtf_pkg::prefix_t                run;
  rqwtf_pkg::prefix_t                prev;
  rqwtf_pkg::prefix_t                fresh;
  rqwtf_pkg::prefix_t                at_x;
  rqwtf_pkg::prefix_t                final_run;
  logic                              counting;
  logic                              past_k;
  logic                              full_win;
  logic [rqwtf_pkg::QSUM_W-1:0]      diff;
  logic [rqwtf_pkg::WSUM_W-1:0]      wsum;
  logic [2*rqwtf_pkg::K_W-1:0]       thresh;
  logic                              trim_now;
  logic [rqwtf_pkg::POS_W-1:0]       x;
  logic [rqwtf_pkg::POS_W-1:0]       length;

  always_comb begin
    counting   = s1.active && !trimmed;
    fresh.qsum = run.qsum + rqwtf_pkg::QSUM_W'(s1.qual);
    fresh.ncnt = run.ncnt + rqwtf_pkg::NCNT_W'(s1.is_n);
    // With a window of one the window start is this very base.
    at_x       = (s1.k == rqwtf_pkg::K_W'(1)) ? fresh : rd_data;
    past_k     = rqwtf_pkg::POS_W'(s1.k) <= s1.pos;
    full_win   = rqwtf_pkg::POS_W'(s1.k - rqwtf_pkg::K_W'(1)) <= s1.pos;
    diff       = fresh.qsum - (past_k ? prev.qsum : '0);
    wsum       = diff[rqwtf_pkg::WSUM_W-1:0];
    thresh     = min_window_quality * s1.k;
    trim_now   = counting && !s1.last && full_win
                 && ((2*rqwtf_pkg::K_W)'(wsum) < thresh);
    x          = s1.pos + rqwtf_pkg::POS_W'(1) - rqwtf_pkg::POS_W'(s1.k);
    length     = s1.active ? s1.pos + rqwtf_pkg::POS_W'(1) : s1.pos;
    final_run  = counting ? fresh : run;
  end

  assign wr_en   = s1_fire && counting;
  assign wr_addr = s1.pos[rqwtf_pkg::WIN_AW-1:0];
  assign wr_data = fresh;

  assign rec_valid          = s1_fire && s1.last;
  assign rec.read_length    = length;
  assign rec.trimmed_length = trimmed ? trim_point : length;
  assign rec.ncnt           = final_run.ncnt;
  assign rec.qsum           = final_run.qsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      trimmed <= 1'b0;
      run     <= '0;
    end else if (s1_fire) begin
      if (s1.last) begin
        trimmed <= 1'b0;
        run     <= '0;
      end else if (counting) begin
        if (trim_now) begin
          trimmed <= 1'b1;
          run     <= at_x;
        end else begin
          run <= fresh;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && counting) begin
      prev <= at_x;
      if (trim_now) begin
        trim_point <= x;
      end
    end
  end

endmodule

/* hw/rtl/rqwtf_verdict.sv */
// Result register and read verdict of the read quality window trim filter.
module rqwtf_verdict (
  input  logic               clk,
  input  logic               rst,
  input  rqwtf_pkg::cfg_t    regs,
  input  rqwtf_pkg::record_t rec,
  input  logic               rec_valid,
  output logic               out_free,
  rqwtf_out_if.source        results
);

  rqwtf_pkg::record_t                          held;
  logic [rqwtf_pkg::Q_W+rqwtf_pkg::POS_W-1:0]  avg_floor;
  logic [rqwtf_pkg::VERDICT_W-1:0]             verdict;

  assign out_free = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (rec_valid) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid) begin
      held <= rec;
    end
  end

  // The integer average is below the limit exactly when the sum is below limit times length.
  always_comb begin
    avg_floor = regs.min_average_quality * held.read_length;
    if (held.read_length == '0) begin
      verdict = rqwtf_pkg::VERDICT_EMPTY;
    end else if (held.ncnt > regs.max_n_count) begin
      verdict = rqwtf_pkg::VERDICT_MANY_N;
    end else if ((rqwtf_pkg::Q_W+rqwtf_pkg::POS_W)'(held.qsum) < avg_floor) begin
      verdict = rqwtf_pkg::VERDICT_LOW_AVG;
    end else if (held.trimmed_length < regs.min_read_length) begin
      verdict = rqwtf_pkg::VERDICT_SHORT;
    end else begin
      verdict = rqwtf_pkg::VERDICT_KEEP;
    end
  end

  assign results.verdict        = verdict;
  assign results.keep           = (verdict == rqwtf_pkg::VERDICT_KEEP);
  assign results.trimmed_length = held.trimmed_length;
  assign results.read_length    = held.read_length;
  assign results.n_count        = held.ncnt;
  assign results.quality_sum    = held.qsum;

endmodule

/* tb/sv/tb_read_quality_window_trim_filter.sv */
// Self-checking testbench for the read quality window trim filter, with its verdict scoreboard.
`timescale 1ns / 100ps

module tb_read_quality_window_trim_filter;
  import rqwtf_pkg::*;

  // Phred+33 offset and the highest quality score a byte may stand for.
  localparam int unsigned PHRED_OFFSET = 33;
  localparam int unsigned PHRED_CAP    = 93;
  // Bases beyond this position are not counted; last still closes the read.
  localparam int unsigned MAX_BASES    = 65535;
  localparam int unsigned N_SAT        = 65535;
  localparam int unsigned QSUM_SAT     = 8388607;

  // One verdict item as it leaves the block.
  typedef struct packed {
    logic                 keep;
    logic [VERDICT_W-1:0] verdict;
    logic [POS_W-1:0]     trimmed_length;
    logic [POS_W-1:0]     read_length;
    logic [NCNT_W-1:0]    n_count;
    logic [QSUM_W-1:0]    quality_sum;
  } read_verdict_t;

  // Tracks the read in progress, predicts its verdict and checks the block against it.
  class read_filter_scoreboard;
    int unsigned max_n, win_cfg, min_win_q, min_avg_q, min_len;
    logic [Q_W-1:0] ring_q [MAX_WINDOW];
    bit             ring_n [MAX_WINDOW];
    int unsigned    pos, win_sum, trim_at, n_total, read_k;
    longint unsigned q_total;
    bit             is_trimmed;
    read_verdict_t  verdicts_due [$];
    int             errors;

    function new();
      max_n     = 32'(CFG_RESET.max_n_count);
      win_cfg   = 32'(CFG_RESET.window_size);
      min_win_q = 32'(CFG_RESET.min_window_quality);
      min_avg_q = 32'(CFG_RESET.min_average_quality);
      min_len   = 32'(CFG_RESET.min_read_length);
      errors    = 0;
      clear_read();
    endfunction

    function void clear_read();
      foreach (ring_q[i]) begin
        ring_q[i] = '0;
        ring_n[i] = 1'b0;
      end
      pos        = 0;
      win_sum    = 0;
      trim_at    = 0;
      n_total    = 0;
      q_total    = 0;
      is_trimmed = 1'b0;
      read_k     = 1;
    endfunction

    // Ring slot of a position; the ring depth is a power of two.
    function logic [WIN_AW-1:0] slot(int unsigned p);
      return p[WIN_AW-1:0];
    endfunction

    // Window length the block uses for a read started now.
    function int unsigned window_len();
      if (win_cfg == 0) return 1;
      if (win_cfg > MAX_WINDOW) return MAX_WINDOW;
      return win_cfg;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MAX_N_COUNT:         max_n     = 32'(val);
        REG_WINDOW_SIZE:         win_cfg   = 32'(val[K_W-1:0]);
        REG_MIN_WINDOW_QUALITY:  min_win_q = 32'(val[Q_W-1:0]);
        REG_MIN_AVERAGE_QUALITY: min_avg_q = 32'(val[Q_W-1:0]);
        REG_MIN_READ_LENGTH:     min_len   = 32'(val);
        default: ;
      endcase
    endfunction

    function void note_base(logic [7:0] b, logic [7:0] qc, logic last);
      int unsigned q, k, len, x, nc;
      longint unsigned qs;
      bit isn;
      logic [VERDICT_W-1:0] v;
      read_verdict_t want;
      if (pos == 0) read_k = window_len();
      if (pos < MAX_BASES) begin
        if (!is_trimmed) begin
          k   = read_k;
          q   = (qc < PHRED_OFFSET) ? 0 : qc - PHRED_OFFSET;
          if (q > PHRED_CAP) q = PHRED_CAP;
          isn = (b == BASE_N);
          if (pos >= k) win_sum -= ring_q[slot(pos - k)];
          ring_q[slot(pos)] = Q_W'(q);
          ring_n[slot(pos)] = isn;
          win_sum += q;
          n_total += isn;
          q_total += q;
          if (!last && pos + 1 >= k) begin
            x = pos + 1 - k;
            if (win_sum / k < min_win_q) begin
              is_trimmed = 1'b1;
              trim_at    = x;
              // Only the window's first base stays in the totals.
              for (int i = 1; i < k; i++) begin
                q_total -= ring_q[slot(x + i)];
                n_total -= ring_n[slot(x + i)];
              end
            end
          end
        end
        pos++;
      end
      if (last) begin
        len = pos;
        x   = is_trimmed ? trim_at : len;
        qs  = q_total;
        nc  = n_total;
        if (len == 0)                 v = VERDICT_EMPTY;
        else if (nc > max_n)          v = VERDICT_MANY_N;
        else if (qs / len < min_avg_q) v = VERDICT_LOW_AVG;
        else if (x < min_len)         v = VERDICT_SHORT;
        else                          v = VERDICT_KEEP;
        if (nc > N_SAT) nc = N_SAT;
        if (qs > QSUM_SAT) qs = QSUM_SAT;
        want.keep           = (v == VERDICT_KEEP);
        want.verdict        = v;
        want.trimmed_length = x[POS_W-1:0];
        want.read_length    = len[POS_W-1:0];
        want.n_count        = nc[NCNT_W-1:0];
        want.quality_sum    = qs[QSUM_W-1:0];
        verdicts_due.push_back(want);
        clear_read();
      end
    endfunction

    function int field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void check_result(read_verdict_t got);
      read_verdict_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: verdict with no read outstanding: expected none, got verdict %0d",
                 $time, got.verdict);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      errors += field_differs("keep", 32'(want.keep), 32'(got.keep));
      errors += field_differs("verdict", 32'(want.verdict), 32'(got.verdict));
      errors += field_differs("trimmed_length", 32'(want.trimmed_length),
                              32'(got.trimmed_length));
      errors += field_differs("read_length", 32'(want.read_length), 32'(got.read_length));
      errors += field_differs("n_count", 32'(want.n_count), 32'(got.n_count));
      errors += field_differs("quality_sum", 32'(want.quality_sum), 32'(got.quality_sum));
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  rqwtf_in_if  bases_if ();
  rqwtf_out_if results_if ();
  rqwtf_cfg_if cfg_if ();

  read_quality_window_trim_filter dut (
    .clk     (clk),
    .rst     (rst),
    .bases   (bases_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  read_filter_scoreboard sb;

  // Percentages of cycles in which the base source holds back and the verdict sink stalls.
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned bases_sent;

  // Ordinary nucleotides for random reads; the unknown base comes from the package.
  logic [7:0] nucleotides [4] = '{8'h41, 8'h43, 8'h47, 8'h54};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A fixed limit well beyond the slowest correct run.
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  // The verdict sink stalls at random, at the rate the current phase sets.
  always @(posedge clk) begin
    results_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // All inputs change only at rising edges, so the handshake seen at the falling edge is the
  // one the next rising edge will complete. Checking here keeps the comparison free of races.
  always @(negedge clk) begin : verdict_monitor
    read_verdict_t got;
    if (!rst && results_if.valid && results_if.ready) begin
      got.keep           = results_if.keep;
      got.verdict        = results_if.verdict;
      got.trimmed_length = results_if.trimmed_length;
      got.read_length    = results_if.read_length;
      got.n_count        = results_if.n_count;
      got.quality_sum    = results_if.quality_sum;
      sb.check_result(got);
    end
  end

  // Offers one base item, with random idle cycles ahead of it, and returns on the edge that
  // accepts it. Valid is left high so that a following item goes out back to back.
  task automatic send_base(logic [7:0] b, logic [7:0] qc, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      bases_if.valid <= 1'b0;
      @(posedge clk);
    end
    bases_if.valid        <= 1'b1;
    bases_if.base_char    <= b;
    bases_if.quality_char <= qc;
    bases_if.last         <= last;
    @(negedge clk);
    while (!bases_if.ready) @(negedge clk);
    @(posedge clk);
    sb.note_base(b, qc, last);
    bases_sent++;
  endtask

  // Stops the base stream and waits until every verdict owed has been taken, then lets the
  // block's output stage settle.
  task automatic drain();
    bases_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(negedge clk);
    while (!cfg_if.ready) @(negedge clk);
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Registers are only ever written with the block idle, between whole reads.
  task automatic apply_settings(logic [15:0] mx, logic [K_W-1:0] w, logic [Q_W-1:0] wq,
                                logic [Q_W-1:0] aq, logic [15:0] ln);
    drain();
    write_reg(REG_MAX_N_COUNT, mx);
    write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(w));
    write_reg(REG_MIN_WINDOW_QUALITY, CFG_DATA_W'(wq));
    write_reg(REG_MIN_AVERAGE_QUALITY, CFG_DATA_W'(aq));
    write_reg(REG_MIN_READ_LENGTH, ln);
    cfg_if.valid <= 1'b0;
  endtask

  // Thresholds lean towards values that let some reads through, with the extremes and the
  // out-of-range window sizes mixed in.
  task automatic random_settings();
    logic [15:0]    mx, ln;
    logic [K_W-1:0] w;
    logic [Q_W-1:0] wq, aq;
    int unsigned    r;
    r = $urandom_range(9);
    if (r < 3)      mx = '0;
    else if (r < 6) mx = 16'($urandom_range(1, 4));
    else if (r < 8) mx = 16'hFFFF;
    else            mx = 16'($urandom_range(16'hFFFF));
    r = $urandom_range(9);
    if (r == 0)      w = '0;
    else if (r == 1) w = 7'd127;
    else if (r == 2) w = 7'd64;
    else if (r == 3) w = K_W'($urandom_range(11, 63));
    else             w = K_W'($urandom_range(1, 10));
    r = $urandom_range(9);
    if (r == 0)      wq = 7'd127;
    else if (r == 1) wq = 7'd93;
    else             wq = Q_W'($urandom_range(0, 40));
    r = $urandom_range(9);
    if (r == 0)      aq = 7'd93;
    else if (r == 1) aq = 7'd127;
    else             aq = Q_W'($urandom_range(0, 35));
    r = $urandom_range(9);
    if (r == 0)      ln = 16'hFFFF;
    else if (r == 1) ln = 16'($urandom_range(16'hFFFF));
    else             ln = 16'($urandom_range(0, 20));
    apply_settings(mx, w, wq, aq, ln);
  endtask

  // A well-formed read: good qualities up to a random drop point and poor ones after it, so
  // that windows fail part-way through; a few bytes of any value are scattered as noise.
  task automatic random_read();
    int unsigned len, drop, r, k;
    logic [7:0]  b, qc;
    k = sb.window_len();
    r = $urandom_range(99);
    if (r < 15)      len = $urandom_range(1, k);
    else if (r < 88) len = $urandom_range(1, 24);
    else             len = $urandom_range(25, 90);
    drop = $urandom_range(0, len + len / 2);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 8)       b = 8'($urandom_range(255));
      else if (r < 22) b = BASE_N;
      else             b = nucleotides[2'($urandom_range(3))];
      r = $urandom_range(99);
      if (r < 8)         qc = 8'($urandom_range(255));
      else if (i < drop) qc = 8'($urandom_range(55, 126));
      else               qc = 8'($urandom_range(0, 50));
      send_base(b, qc, i == len - 1);
    end
  endtask

  initial begin : stimulus
    int unsigned target;
    sb = new();
    rst                   <= 1'b1;
    bases_if.valid        <= 1'b0;
    bases_if.base_char    <= '0;
    bases_if.quality_char <= '0;
    bases_if.last         <= 1'b0;
    cfg_if.valid          <= 1'b0;
    cfg_if.index          <= REG_MAX_N_COUNT;
    cfg_if.data           <= '0;
    bases_sent    = 0;
    src_idle_pct  = 29;
    sink_idle_pct = 46;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed reads under the reset defaults (window of five, no N allowed).
    // A single unknown base with the lowest quality byte: too many N takes priority.
    send_base(BASE_N, 8'h00, 1'b1);
    // A single base with the highest byte, saturated to the cap: too short, no window checked.
    send_base(8'h41, 8'hFF, 1'b1);
    // Six zero-quality bases: the first window fails at position zero, and the low average
    // wins over the short length.
    repeat (5) send_base(8'h41, 8'd33, 1'b0);
    send_base(8'h41, 8'd33, 1'b1);
    // Five good bases then five poor ones: the window from position two fails, and the
    // unknown base inside that window drops out of the count.
    repeat (5) send_base(8'h43, 8'd73, 1'b0);
    send_base(BASE_N, 8'd33, 1'b0);
    repeat (3) send_base(8'h47, 8'd33, 1'b0);
    send_base(8'h54, 8'd33, 1'b1);

    // Everything allowed: extreme byte values on both fields are simply kept.
    apply_settings(16'hFFFF, 7'd64, 7'd0, 7'd0, 16'd0);
    send_base(8'h00, 8'd32, 1'b0);
    send_base(8'hFF, 8'd34, 1'b0);
    send_base(8'hAA, 8'h55, 1'b1);

    // Window size zero stands for one; the strictest thresholds trim after the first base.
    apply_settings(16'd0, 7'd0, 7'd93, 7'd93, 16'hFFFF);
    send_base(8'h41, 8'd126, 1'b0);
    send_base(8'h47, 8'd100, 1'b0);
    send_base(8'h54, 8'd126, 1'b1);

    // An oversized window is clamped, so this short read sees no window check at all.
    apply_settings(16'd1, 7'd127, 7'd127, 7'd0, 16'd1);
    send_base(BASE_N, 8'd60, 1'b0);
    send_base(8'h43, 8'd90, 1'b1);

    // Random reads in three idling patterns, each with two settings drawn at random.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 29;
          sink_idle_pct = 46;
        end
        1: begin
          src_idle_pct  = 46;
          sink_idle_pct = 29;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      repeat (2) begin
        random_settings();
        target = bases_sent + 65;
        while (bases_sent < target) random_read();
      end
    end
    bases_if.valid <= 1'b0;

    // Give the last verdicts time to arrive, then allow for anything stray behind them.
    for (int i = 0; i < 5000 && sb.pending() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d verdicts never arrived: expected %0d more, got none",
               $time, sb.pending(), sb.pending());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/rqwtf_pkg.sv
hw/rtl/rqwtf_if.sv
hw/rtl/rqwtf_prefix_ram.sv
hw/rtl/rqwtf_cfg.sv
hw/rtl/rqwtf_issue.sv
hw/rtl/rqwtf_update.sv
hw/rtl/rqwtf_verdict.sv
hw/rtl/read_quality_window_trim_filter.sv
tb/sv/tb_read_quality_window_trim_filter.sv
